FILE: rtl/core/mfpr_pkg.sv
`default_nettype none

package mfpr_pkg;

    localparam int ATT_W = 16;
    localparam int POS_W = 32;

    localparam logic signed [ATT_W-1:0] ATT_MAX = {1'b0, {(ATT_W-1){1'b1}}};
    localparam logic signed [ATT_W-1:0] ATT_MIN = {1'b1, {(ATT_W-1){1'b0}}};
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MOUNT_FORWARD  = 2'd0,
        MOUNT_BACKWARD = 2'd1,
        MOUNT_LEFT     = 2'd2,
        MOUNT_RIGHT    = 2'd3
    } t_mount;

    typedef struct packed {
        logic signed [ATT_W-1:0] att_w;
        logic signed [ATT_W-1:0] att_x;
        logic signed [ATT_W-1:0] att_y;
        logic signed [ATT_W-1:0] att_z;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_pose_in;

    typedef struct packed {
        logic signed [ATT_W-1:0] out_att_w;
        logic signed [ATT_W-1:0] out_att_x;
        logic signed [ATT_W-1:0] out_att_y;
        logic signed [ATT_W-1:0] out_att_z;
        logic signed [POS_W-1:0] out_north;
        logic signed [POS_W-1:0] out_east;
        logic signed [POS_W-1:0] out_down;
    } t_pose_out;

    // permuted components plus the sign flip still to apply per axis
    typedef struct packed {
        logic signed [ATT_W-1:0] att_w;
        logic signed [ATT_W-1:0] att_0;
        logic signed [ATT_W-1:0] att_1;
        logic signed [ATT_W-1:0] att_2;
        logic signed [POS_W-1:0] pos_0;
        logic signed [POS_W-1:0] pos_1;
        logic signed [POS_W-1:0] pos_2;
        logic        [2:0]       neg;
    } t_perm;

    function automatic logic signed [ATT_W-1:0] neg_sat_att(
        input logic signed [ATT_W-1:0] v
    );
        logic signed [ATT_W-1:0] r;
        r = (v == ATT_MIN) ? ATT_MAX : -v;
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] neg_sat_pos(
        input logic signed [POS_W-1:0] v
    );
        logic signed [POS_W-1:0] r;
        r = (v == POS_MIN) ? POS_MAX : -v;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mount_frame_pose_rotation.sv
// channel   direction  handshake                  payload
// input     in         i_valid / o_ready          i_data (t_pose_in)
// output    out        o_valid / i_ready          o_data (t_pose_out)
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (mount orientation)
//
// three register stages (capture, permute, negate), one request per cycle
// unless i_ready stalls, and o_valid rises once a request has passed all three
// each stage holds its request when the next one is full and stalled, so a
// stall on i_ready backs up stage by stage and o_ready drops only when all are full
// synchronous active-low reset clears the stage valid bits and sets forward mounting
// the orientation is sampled with each request and travels with it
`default_nettype none

module mount_frame_pose_rotation (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire mfpr_pkg::t_pose_in   i_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output mfpr_pkg::t_pose_out       o_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_data
);

    // mounting register, always writable
    mfpr_pkg::t_mount r_mount;

    // capture stage
    logic               r_s1_valid;
    mfpr_pkg::t_pose_in r_s1_data;
    mfpr_pkg::t_mount   r_s1_mode;

    // permute stage handshake
    logic            w_s2_ready;
    logic            w_s2_valid;
    logic            w_s3_ready;
    mfpr_pkg::t_perm w_s2_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mount <= mfpr_pkg::MOUNT_FORWARD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mount <= mfpr_pkg::t_mount'(i_cfg_data);
        end
    end

    // capture stage accepts when empty or when the permute stage takes its request
    assign o_ready = !r_s1_valid || w_s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1_data <= i_data;
            r_s1_mode <= r_mount;
        end
    end

    // axis selection per mounting
    mfpr_permute u_permute (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .o_ready (w_s2_ready),
        .i_data  (r_s1_data),
        .i_mode  (r_s1_mode),
        .o_valid (w_s2_valid),
        .i_ready (w_s3_ready),
        .o_data  (w_s2_data)
    );

    // sign flips with saturation, output register
    mfpr_negate u_negate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .o_ready (w_s3_ready),
        .i_data  (w_s2_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire

FILE: rtl/core/mfpr_permute.sv
`default_nettype none

module mfpr_permute (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire mfpr_pkg::t_pose_in i_data,
    input  wire mfpr_pkg::t_mount  i_mode,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output mfpr_pkg::t_perm        o_data
);

    logic            r_valid;
    mfpr_pkg::t_perm r_data;
    mfpr_pkg::t_perm n_data;
    logic            w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_data       = '0;
        n_data.att_w = i_data.att_w;
        // third axis is always minus y
        n_data.att_2 = i_data.att_y;
        n_data.pos_2 = i_data.pos_y;
        unique case (i_mode)
            mfpr_pkg::MOUNT_FORWARD: begin
                n_data.att_0 = i_data.att_z;
                n_data.att_1 = i_data.att_x;
                n_data.pos_0 = i_data.pos_z;
                n_data.pos_1 = i_data.pos_x;
                n_data.neg   = 3'b101;
            end
            mfpr_pkg::MOUNT_BACKWARD: begin
                n_data.att_0 = i_data.att_z;
                n_data.att_1 = i_data.att_x;
                n_data.pos_0 = i_data.pos_z;
                n_data.pos_1 = i_data.pos_x;
                n_data.neg   = 3'b011;
            end
            mfpr_pkg::MOUNT_LEFT: begin
                n_data.att_0 = i_data.att_x;
                n_data.att_1 = i_data.att_z;
                n_data.pos_0 = i_data.pos_x;
                n_data.pos_1 = i_data.pos_z;
                n_data.neg   = 3'b001;
            end
            default: begin
                n_data.att_0 = i_data.att_x;
                n_data.att_1 = i_data.att_z;
                n_data.pos_0 = i_data.pos_x;
                n_data.pos_1 = i_data.pos_z;
                n_data.neg   = 3'b111;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

FILE: rtl/core/mfpr_negate.sv
`default_nettype none

module mfpr_negate (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire mfpr_pkg::t_perm   i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output mfpr_pkg::t_pose_out    o_data
);

    logic                r_valid;
    mfpr_pkg::t_pose_out r_data;
    mfpr_pkg::t_pose_out n_data;
    logic                w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    // saturating sign flip, the most negative value maps to the largest positive
    always_comb begin
        n_data.out_att_w = i_data.att_w;
        n_data.out_att_x = i_data.neg[2] ? mfpr_pkg::neg_sat_att(i_data.att_0) : i_data.att_0;
        n_data.out_att_y = i_data.neg[1] ? mfpr_pkg::neg_sat_att(i_data.att_1) : i_data.att_1;
        n_data.out_att_z = i_data.neg[0] ? mfpr_pkg::neg_sat_att(i_data.att_2) : i_data.att_2;
        n_data.out_north = i_data.neg[2] ? mfpr_pkg::neg_sat_pos(i_data.pos_0) : i_data.pos_0;
        n_data.out_east  = i_data.neg[1] ? mfpr_pkg::neg_sat_pos(i_data.pos_1) : i_data.pos_1;
        n_data.out_down  = i_data.neg[0] ? mfpr_pkg::neg_sat_pos(i_data.pos_2) : i_data.pos_2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

FILE: rtl/core/mfpr_checker.sv
`default_nettype none

module mfpr_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_ready,
    input wire mfpr_pkg::t_pose_in  i_data,
    input wire logic                o_valid,
    input wire logic                i_ready,
    input wire mfpr_pkg::t_pose_out o_data
);

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");

    // unstalled request shows up at the output with its scalar part intact
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_valid && o_ready) ##1 (i_rst_n && i_ready) ##1 (i_rst_n && i_ready)
        |=> (o_valid && o_data.out_att_w == $past(i_data.att_w, 3)))
        else $error("request lost or scalar part altered");

    // the down axis is always a saturated negation, never the most negative value
    a_down_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.out_down != mfpr_pkg::POS_MIN))
        else $error("down axis not saturated");

endmodule

bind mount_frame_pose_rotation mfpr_checker u_mfpr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

`default_nettype wire

FILE: sim/mount_frame_pose_rotation_tb.sv
`timescale 1ns / 1ps

module mount_frame_pose_rotation_tb;
    import mfpr_pkg::*;

    localparam int PHASE_POSES = 160;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SQUEEZE_AT  = 400;  // results checked before the long output stall
    localparam int SQUEEZE_LEN = 150;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_pose_in   in_data = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [1:0] cfg_data = '0;
    logic       o_ready;
    logic       o_valid;
    t_pose_out  o_data;
    logic       o_cfg_ready;

    // requests waiting to be offered, and rotated poses waiting to come out
    t_pose_in  pose_q[$];
    t_pose_out rotated_q[$];

    t_mount mount_now = MOUNT_FORWARD;  // orientation the block holds right now
    bit     calm = 1'b0;                // no idling on either side while set
    bit     squeezed = 1'b0;
    int     tx_gap = 0;
    int     rx_hold = 0;
    int     n_sent = 0;
    int     n_checked = 0;
    int     n_err = 0;
    int     n_cfg = 0;
    int     n_cycles = 0;
    int     per_mount[4] = '{0, 0, 0, 0};

    mount_frame_pose_rotation u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_ready     (o_ready),
        .i_data      (in_data),
        .o_valid     (o_valid),
        .i_ready     (out_ready),
        .o_data      (o_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // negate, clamping the one value whose negation does not fit
    function automatic longint flip_sat(input longint v, input int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        return (-v > hi) ? hi : -v;
    endfunction

    // signed axis permutation for one vector; the third axis is always -y
    function automatic void turn_axes(input longint vx, input longint vy, input longint vz,
                                      input int bits, input t_mount m,
                                      output longint o0, output longint o1,
                                      output longint o2);
        o2 = flip_sat(vy, bits);
        case (m)
            MOUNT_FORWARD: begin
                o0 = flip_sat(vz, bits);
                o1 = vx;
            end
            MOUNT_BACKWARD: begin
                o0 = vz;
                o1 = flip_sat(vx, bits);
            end
            MOUNT_LEFT: begin
                o0 = vx;
                o1 = vz;
            end
            default: begin
                o0 = flip_sat(vx, bits);
                o1 = flip_sat(vz, bits);
            end
        endcase
    endfunction

    // quaternion sandwich by the mounting rotation, reduced to axis swaps
    function automatic t_pose_out rotate_pose(input t_pose_in p, input t_mount m);
        t_pose_out r;
        longint a0, a1, a2, q0, q1, q2;
        turn_axes(p.att_x, p.att_y, p.att_z, ATT_W, m, a0, a1, a2);
        turn_axes(p.pos_x, p.pos_y, p.pos_z, POS_W, m, q0, q1, q2);
        r.out_att_w = p.att_w;
        r.out_att_x = ATT_W'(a0);
        r.out_att_y = ATT_W'(a1);
        r.out_att_z = ATT_W'(a2);
        r.out_north = POS_W'(q0);
        r.out_east  = POS_W'(q1);
        r.out_down  = POS_W'(q2);
        return r;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $display("%0t: mismatch on %s, expected %0d, got %0d", $time, name, want, got);
            n_err++;
        end
    endfunction

    // mostly back to back, sometimes a few cycles, rarely a long gap
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // random fields lean toward the extremes, where the negation clamps
    function automatic logic signed [ATT_W-1:0] rand_att();
        case ($urandom_range(0, 11))
            0: return ATT_MIN;
            1: return ATT_MAX;
            2: return '0;
            3: return '1;
            default: return ATT_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] rand_pos();
        case ($urandom_range(0, 11))
            0: return POS_MIN;
            1: return POS_MAX;
            2: return '0;
            3: return '1;
            4: return POS_W'($signed(16'($urandom)));  // small distances
            default: return POS_W'($urandom);
        endcase
    endfunction

    function automatic t_pose_in make_pose(
        input logic signed [ATT_W-1:0] aw, input logic signed [ATT_W-1:0] ax,
        input logic signed [ATT_W-1:0] ay, input logic signed [ATT_W-1:0] az,
        input logic signed [POS_W-1:0] px, input logic signed [POS_W-1:0] py,
        input logic signed [POS_W-1:0] pz);
        t_pose_in p;
        p.att_w = aw;
        p.att_x = ax;
        p.att_y = ay;
        p.att_z = az;
        p.pos_x = px;
        p.pos_y = py;
        p.pos_z = pz;
        return p;
    endfunction

    // driver: offer queued poses, predict each one as it is accepted
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (in_valid && o_ready) begin
                rotated_q.push_back(rotate_pose(in_data, mount_now));
                per_mount[mount_now]++;
                n_sent++;
            end
            // payload may only change once the current request is taken
            if (!in_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end else if (pose_q.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data <= pose_q.pop_front();
                    tx_gap = pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result against the oldest prediction, stall at random
    always @(posedge clk) begin : monitor
        t_pose_out want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (o_valid && out_ready) begin
                if (rotated_q.size() == 0) begin
                    $display("%0t: unexpected output %p", $time, o_data);
                    n_err++;
                end else begin
                    want = rotated_q.pop_front();
                    check_field("out_att_w", want.out_att_w, o_data.out_att_w);
                    check_field("out_att_x", want.out_att_x, o_data.out_att_x);
                    check_field("out_att_y", want.out_att_y, o_data.out_att_y);
                    check_field("out_att_z", want.out_att_z, o_data.out_att_z);
                    check_field("out_north", want.out_north, o_data.out_north);
                    check_field("out_east", want.out_east, o_data.out_east);
                    check_field("out_down", want.out_down, o_data.out_down);
                end
                n_checked++;
            end
            // one long hold-off so the pipeline fills and backs up into o_ready
            if (!squeezed && n_checked >= SQUEEZE_AT) begin
                squeezed = 1'b1;
                rx_hold = SQUEEZE_LEN;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                rx_hold = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // block until every request went in and every result came out
    task automatic wait_idle();
        while (pose_q.size() != 0 || in_valid || rotated_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_mount(input t_mount m);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        mount_now = m;
        n_cfg++;
    endtask

    task automatic queue_directed();
        // zero, both rails, all ones, mixed rails, a mid-range quaternion with mixed signs
        pose_q.push_back(make_pose('0, '0, '0, '0, '0, '0, '0));
        pose_q.push_back(make_pose(ATT_MAX, ATT_MAX, ATT_MAX, ATT_MAX,
                                   POS_MAX, POS_MAX, POS_MAX));
        pose_q.push_back(make_pose(ATT_MIN, ATT_MIN, ATT_MIN, ATT_MIN,
                                   POS_MIN, POS_MIN, POS_MIN));
        pose_q.push_back(make_pose('1, '1, '1, '1, '1, '1, '1));
        pose_q.push_back(make_pose(ATT_MAX, ATT_MIN, 16'sd1, -16'sd2,
                                   POS_MIN, POS_MAX, 32'sd65536));
        pose_q.push_back(make_pose(16'sd16384, 16'sd0, -16'sd16384, 16'sd11585,
                                   -32'sd1, POS_MIN, POS_MAX));
    endtask

    initial begin : stimulus
        t_mount order[8];
        order = '{MOUNT_RIGHT, MOUNT_FORWARD, MOUNT_LEFT, MOUNT_BACKWARD,
                  MOUNT_RIGHT, MOUNT_BACKWARD, MOUNT_FORWARD, MOUNT_LEFT};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every orientation, forward straight out of reset
        queue_directed();
        wait_idle();
        set_mount(MOUNT_BACKWARD);
        queue_directed();
        wait_idle();
        set_mount(MOUNT_LEFT);
        queue_directed();
        wait_idle();
        set_mount(MOUNT_RIGHT);
        queue_directed();
        wait_idle();

        // random phases, each under its own orientation, some without idling
        for (int ph = 0; ph < 8; ph++) begin
            set_mount(order[ph]);
            calm = (ph % 3 == 1);
            for (int k = 0; k < PHASE_POSES; k++)
                pose_q.push_back(make_pose(rand_att(), rand_att(), rand_att(), rand_att(),
                                           rand_pos(), rand_pos(), rand_pos()));
            wait_idle();
        end
        calm = 1'b0;

        // let anything stray still surface
        repeat (10) @(posedge clk);
        $display("covered %0d poses: forward %0d, backward %0d, left %0d, right %0d",
                 n_sent, per_mount[MOUNT_FORWARD], per_mount[MOUNT_BACKWARD],
                 per_mount[MOUNT_LEFT], per_mount[MOUNT_RIGHT]);
        $display("%0d orientation writes, %0d results checked, %0d errors",
                 n_cfg, n_checked, n_err);
        if (n_err == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
